@@ hdl/srmq_pkg.sv @@
// ----------------------------------------------------------------------------
// srmq_pkg: shared types and constants for the sparse-table range-max block
// Request and result layouts, mode and status codes, controller states and
// the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package srmq_pkg;

  // Table geometry
  localparam int MAX_ELEMENTS = 1024;
  localparam int LEVELS       = 11;
  localparam int MEM_DEPTH    = LEVELS * MAX_ELEMENTS;
  localparam int ADDR_W       = $clog2(MEM_DEPTH);

  // Field widths
  localparam int MODE_W   = 2;
  localparam int IDX_W    = 10;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;

  // Element count, level counter and query level widths
  localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
  localparam int CMP_W  = CNT_W + 1;
  localparam int LVL_W  = $clog2(LEVELS);
  localparam int LVL_CW = $clog2(LEVELS + 1);

  // Request modes
  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD    = 2'd0,
    MODE_QUERY   = 2'd1,
    MODE_RESTART = 2'd2
  } mode_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_RANGE = 2'd1,
    STATUS_FULL      = 2'd2
  } status_t;

  // Request payload
  typedef struct packed {
    logic [MODE_W-1:0]       mode;
    logic [IDX_W-1:0]        left_index;
    logic [IDX_W-1:0]        right_index;
    logic signed [VAL_W-1:0] element_value;
  } in_t;

  // Result payload
  typedef struct packed {
    logic signed [VAL_W-1:0] range_maximum;
    logic [STATUS_W-1:0]     status;
  } out_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_LD_BASE,
    ST_LD_READ,
    ST_LD_WRITE,
    ST_Q_READ,
    ST_Q_CMP,
    ST_EMIT
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic decode;
    logic ld_base;
    logic ld_read;
    logic ld_write;
    logic q_read;
    logic q_cmp;
    logic finish;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              load_full;
    logic              range_bad;
    logic              lvl_ok;
    logic              lvl_next_ok;
  } sts_t;

  // Flat table address of entry (level, index)
  function automatic logic [ADDR_W-1:0] mem_addr(input logic [LVL_W-1:0] lvl,
                                                 input logic [IDX_W-1:0] idx);
    return ADDR_W'(ADDR_W'(lvl) * ADDR_W'(MAX_ELEMENTS) + ADDR_W'(idx));
  endfunction

endpackage

@@ hdl/srmq_ctrl.sv @@
// ----------------------------------------------------------------------------
// srmq_ctrl: sequencing state machine
// Accepts one request at a time, walks the load level loop or the query
// read/compare steps, and emits the result for one cycle.
// ----------------------------------------------------------------------------
module srmq_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  srmq_pkg::sts_t  sts,
  output srmq_pkg::cmd_t  cmd,
  output logic            busy,
  output logic            out_valid
);
  import srmq_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        case (sts.mode)
          MODE_LOAD:  state_nxt = sts.load_full ? ST_EMIT : ST_LD_BASE;
          MODE_QUERY: state_nxt = sts.range_bad ? ST_EMIT : ST_Q_READ;
          default:    state_nxt = ST_EMIT;
        endcase
      end
      ST_LD_BASE: begin
        state_nxt = sts.lvl_ok ? ST_LD_READ : ST_EMIT;
      end
      ST_LD_READ: begin
        state_nxt = ST_LD_WRITE;
      end
      ST_LD_WRITE: begin
        state_nxt = sts.lvl_next_ok ? ST_LD_READ : ST_EMIT;
      end
      ST_Q_READ: begin
        state_nxt = ST_Q_CMP;
      end
      ST_Q_CMP: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    cmd       = '0;
    busy      = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        busy        = 1'b0;
        cmd.capture = start;
      end
      ST_DECODE:   cmd.decode   = 1'b1;
      ST_LD_BASE:  cmd.ld_base  = 1'b1;
      ST_LD_READ:  cmd.ld_read  = 1'b1;
      ST_LD_WRITE: cmd.ld_write = 1'b1;
      ST_Q_READ:   cmd.q_read   = 1'b1;
      ST_Q_CMP:    cmd.q_cmp    = 1'b1;
      ST_EMIT: begin
        cmd.finish = 1'b1;
        out_valid  = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

@@ hdl/srmq_dpath.sv @@
// ----------------------------------------------------------------------------
// srmq_dpath: sparse-table datapath
// Holds the request, the element count and the level table memory, builds
// one table level per read/write pair on a load and merges two windows on a
// query.
// ----------------------------------------------------------------------------
module srmq_dpath (
  input  logic            clk,
  input  logic            rst_n,
  input  srmq_pkg::in_t   in_data,
  input  srmq_pkg::cmd_t  cmd,
  output srmq_pkg::sts_t  sts,
  output srmq_pkg::out_t  out_data
);
  import srmq_pkg::*;

  // Level table: one flat array, one write and two read addresses
  logic [VAL_W-1:0] level_mem_r [MEM_DEPTH];

  in_t                     item_r;
  logic [CNT_W-1:0]        count_r;
  logic [CNT_W-1:0]        count_nxt;
  logic [LVL_CW-1:0]       lvl_r;
  logic [LVL_CW-1:0]       lvl_nxt;
  logic [LVL_W-1:0]        k_r;
  logic [LVL_W-1:0]        k_nxt;
  logic signed [VAL_W-1:0] cur_r;
  logic signed [VAL_W-1:0] cur_nxt;
  logic signed [VAL_W-1:0] res_max_r;
  logic signed [VAL_W-1:0] res_max_nxt;
  status_t                 status_r;
  status_t                 status_nxt;
  logic signed [VAL_W-1:0] rd_a_r;
  logic signed [VAL_W-1:0] rd_b_r;

  logic [IDX_W-1:0]        elem_idx;
  logic [CNT_W-1:0]        half_len;
  logic [CNT_W-1:0]        query_len;
  logic [IDX_W-1:0]        first_end;
  logic [LVL_CW-1:0]       lvl_plus;
  logic                    load_full;
  logic                    range_bad;
  logic signed [VAL_W-1:0] ld_max;
  logic signed [VAL_W-1:0] q_max;
  logic                    mem_we;
  logic [ADDR_W-1:0]       waddr;
  logic [VAL_W-1:0]        wdata;
  logic [ADDR_W-1:0]       raddr_a;
  logic [ADDR_W-1:0]       raddr_b;

  // Level check: level l fits below LEVELS and its window starts at or past 0
  function automatic logic level_fits(input logic [LVL_CW-1:0] l,
                                      input logic [CNT_W-1:0] cnt);
    logic [CMP_W-1:0] span;
    logic [CMP_W-1:0] top;
    span = CMP_W'(1) << l;
    top  = CMP_W'(cnt) + CMP_W'(1);
    return (l < LVL_CW'(LEVELS)) && (top >= span);
  endfunction

  // Decode flags and window arithmetic
  always_comb begin
    elem_idx  = count_r[IDX_W-1:0];
    lvl_plus  = LVL_CW'(lvl_r + LVL_CW'(1));
    half_len  = CNT_W'(1) << LVL_CW'(lvl_r - LVL_CW'(1));
    load_full = (count_r >= CNT_W'(MAX_ELEMENTS));
    range_bad = (item_r.left_index > item_r.right_index) ||
                (CNT_W'(item_r.right_index) >= count_r);
    query_len = CNT_W'(CNT_W'(item_r.right_index) - CNT_W'(item_r.left_index)
                       + CNT_W'(1));
    first_end = IDX_W'(CNT_W'(item_r.left_index) + (CNT_W'(1) << k_r) - CNT_W'(1));
    ld_max    = (rd_a_r > cur_r) ? rd_a_r : cur_r;
    q_max     = (rd_a_r > rd_b_r) ? rd_a_r : rd_b_r;
  end

  // Query level: index of the top set bit of the length, clamped
  always_comb begin
    k_nxt = k_r;
    if (cmd.decode) begin
      k_nxt = '0;
      for (int i = 0; i < CNT_W; i++) begin
        if (query_len[i]) k_nxt = LVL_W'(i);
      end
      if (k_nxt > LVL_W'(LEVELS - 1)) k_nxt = LVL_W'(LEVELS - 1);
    end
  end

  // Status to the controller
  always_comb begin
    sts.mode        = item_r.mode;
    sts.load_full   = load_full;
    sts.range_bad   = range_bad;
    sts.lvl_ok      = level_fits(lvl_r, count_r);
    sts.lvl_next_ok = level_fits(lvl_plus, count_r);
  end

  // Memory port selection
  always_comb begin
    mem_we  = cmd.ld_base | cmd.ld_write;
    waddr   = mem_addr(LVL_W'(0), elem_idx);
    wdata   = item_r.element_value;
    raddr_a = mem_addr(k_r, first_end);
    raddr_b = mem_addr(k_r, item_r.right_index);
    if (cmd.ld_write) begin
      waddr = mem_addr(LVL_W'(lvl_r), elem_idx);
      wdata = ld_max;
    end
    if (cmd.ld_read) begin
      raddr_a = mem_addr(LVL_W'(lvl_r - LVL_CW'(1)),
                         IDX_W'(CNT_W'(elem_idx) - half_len));
    end
  end

  // Table write and registered reads
  always_ff @(posedge clk) begin
    if (mem_we) begin
      level_mem_r[waddr] <= wdata;
    end
    rd_a_r <= level_mem_r[raddr_a];
    rd_b_r <= level_mem_r[raddr_b];
  end

  // Payload next values
  always_comb begin
    lvl_nxt     = lvl_r;
    cur_nxt     = cur_r;
    res_max_nxt = res_max_r;
    status_nxt  = status_r;
    if (cmd.capture) begin
      res_max_nxt = '0;
    end
    if (cmd.decode) begin
      lvl_nxt = LVL_CW'(1);
      case (item_r.mode)
        MODE_LOAD:  status_nxt = load_full ? STATUS_FULL : STATUS_OK;
        MODE_QUERY: status_nxt = range_bad ? STATUS_BAD_RANGE : STATUS_OK;
        default:    status_nxt = STATUS_OK;
      endcase
    end
    if (cmd.ld_base) begin
      cur_nxt = item_r.element_value;
    end
    if (cmd.ld_write) begin
      cur_nxt = ld_max;
      lvl_nxt = lvl_plus;
    end
    if (cmd.q_cmp) begin
      res_max_nxt = q_max;
    end
  end

  // Hold request and working registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_data;
    end
    lvl_r     <= lvl_nxt;
    k_r       <= k_nxt;
    cur_r     <= cur_nxt;
    res_max_r <= res_max_nxt;
    status_r  <= status_nxt;
  end

  // Element count: advance on a kept load, drop to zero on restart
  always_comb begin
    count_nxt = count_r;
    if (cmd.finish) begin
      case (item_r.mode)
        MODE_LOAD: begin
          if (!load_full) count_nxt = CNT_W'(count_r + CNT_W'(1));
        end
        MODE_RESTART: count_nxt = '0;
        default:      count_nxt = count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Result
  always_comb begin
    out_data.range_maximum = res_max_r;
    out_data.status        = status_r;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_ELEMENTS))
    else $error("element count past capacity");

  a_load_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ld_base |-> (count_r < CNT_W'(MAX_ELEMENTS)))
    else $error("table write while full");

  a_write_level: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ld_write |-> (lvl_r < LVL_CW'(LEVELS)) && (lvl_r != LVL_CW'(0)))
    else $error("level write outside table");

endmodule

@@ hdl/sparse_table_range_max.sv @@
// ----------------------------------------------------------------------------
// sparse_table_range_max: sparse-table range-maximum block
// Appends signed values to a list and answers range-maximum queries from a
// per-level table of power-of-two windows.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken at a rising edge with start high and busy low. Mode
//   load appends element_value, query returns the maximum over
//   [left_index, right_index], restart empties the list. Each request gives
//   exactly one result, shown on out_data for one cycle with out_valid high;
//   the receiver must take it then, as there is no back-pressure.
//   A load builds one table level per read/write pair on the single table
//   write port; a query reads both windows at once and compares next cycle.
//   busy drops and a new request can be taken in the cycle after out_valid.
//   Reset clears the state machine and the element count. The table memory
//   is not cleared: only entries written since the last restart are read.
// ----------------------------------------------------------------------------
module sparse_table_range_max (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  srmq_pkg::in_t   in_data,
  output logic            out_valid,
  output srmq_pkg::out_t  out_data
);
  import srmq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencing
  srmq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // Table, counters and result registers
  srmq_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  a_emit_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy ##1 !busy && !out_valid)
    else $error("result not followed by idle");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == STATUS_BAD_RANGE ||
                   out_data.status == STATUS_FULL))
      |-> (out_data.range_maximum == '0))
    else $error("error result carries nonzero maximum");

endmodule
